// ===== hw/rtl/tbs_pkg.sv =====
// Shared types, codes and constants of the token bucket packet shaper.
package tbs_pkg;

   // Field widths
   localparam int CREDIT_W = 31;
   localparam int TIME_W   = 32;
   localparam int TAG_W    = 16;
   localparam int SIZE_W   = 16;
   localparam int REFILL_W = 32;   // bit 31 set means "at least 2^31", i.e. saturating
   localparam int PROD_W   = 63;   // elapsed (32) times rate (31)

   // Packets of this size or more are never queued
   localparam logic [SIZE_W-1:0] MAX_PACKET_BYTES = 16'd2048;

   // Divide by ten: floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for x < 2^35
   localparam logic [34:0] RECIP_10    = 35'd27487790695;
   localparam int          RECIP_SHIFT = 38;
   // Products at or above ten times 2^31 refill the bucket to the top anyway
   localparam logic [PROD_W-1:0] SAT_LIMIT = 63'd21474836480;

   // Decoupling FIFO between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Input kinds
   localparam logic KIND_PACKET = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_BUCKET_DEPTH = 2'd0;
   localparam logic [1:0] CSR_RATE         = 2'd1;
   localparam logic [1:0] CSR_OUT_EN       = 2'd2;

   typedef enum logic [2:0] {
      ST_QSENT    = 3'd0,
      ST_QDISC    = 3'd1,
      ST_SENT     = 3'd2,
      ST_DISC     = 3'd3,
      ST_QUEUED   = 3'd4,
      ST_FULL     = 3'd5,
      ST_OVERSIZE = 3'd6,
      ST_TICK     = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_LOAD,
      B_CHECK,
      B_FINAL
   } back_state_type;

   // One classified item on its way from front to back
   typedef struct packed {
      logic                kind;
      logic [TAG_W-1:0]    tag;
      logic [SIZE_W-1:0]   size;
      logic [REFILL_W-1:0] refill;
   } item_type;

   // Configuration seen by the back end
   typedef struct packed {
      logic [CREDIT_W-1:0] bucket_depth;
      logic                out_en;
      logic                credit_load;
   } cfg_type;

endpackage

// ===== hw/rtl/token_bucket_packet_shaper.sv =====
// Top level of the token bucket packet shaper: ports, registers and wiring.
//
//  Channel  Direction  Signals                    Content
//  req      in         tvalid tready tdata tuser  one packet arrival or timer tick
//  rsp      out        tvalid tready tdata tuser  released, sent, queued or dropped
//                      tlast                      packets; last result of an item
//  csr      in         valid ready index data     bucket depth, rate, output enable
//
// Cycles: the front end is a three-stage pipe (time difference, multiply, partial
// products of the divide by ten, recombined on the way into the FIFO) and takes one
// item per cycle while its FIFO has room. The back end takes an item in its idle state
// and gives its last result in its final state. Each queued packet it releases, and the
// final fit check when packets remain queued, pass a load and a check state, as the
// descriptor store has one registered read port.
// Reset is synchronous; the descriptor store is not cleared.
// Either side may stall at any time; the result register frees the back end.
module token_bucket_packet_shaper #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // now[31:0], pkt_tag[47:32], pkt_size[63:48]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_tag[15:0], out_size[31:16], credit_left[62:32]
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data
);

   logic [tbs_pkg::CREDIT_W-1:0]  bucket_depth_ff, bucket_depth_in;
   logic [tbs_pkg::CREDIT_W-1:0]  rate_ff, rate_in;
   logic                          out_en_ff, out_en_in;
   tbs_pkg::cfg_type              cfg;

   logic                          push_valid, push_full;
   tbs_pkg::item_type             push_item;
   logic                          pop_valid, pop;
   tbs_pkg::item_type             pop_item;

   tbs_pkg::status_type           rsp_status;
   logic [tbs_pkg::TAG_W-1:0]     rsp_tag;
   logic [tbs_pkg::SIZE_W-1:0]    rsp_size;
   logic [tbs_pkg::CREDIT_W-1:0]  rsp_credit;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      bucket_depth_in = bucket_depth_ff;
      rate_in         = rate_ff;
      out_en_in       = out_en_ff;
      if (csr_valid) begin
         case (csr_index)
            tbs_pkg::CSR_BUCKET_DEPTH: bucket_depth_in = csr_data;
            tbs_pkg::CSR_RATE:         rate_in         = csr_data;
            tbs_pkg::CSR_OUT_EN:       out_en_in       = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_depth_ff <= '0;
         rate_ff         <= '0;
         out_en_ff       <= 1'b1;
      end else begin
         bucket_depth_ff <= bucket_depth_in;
         rate_ff         <= rate_in;
         out_en_ff       <= out_en_in;
      end
   end

   always_comb begin
      cfg.bucket_depth = bucket_depth_in;
      cfg.out_en       = out_en_ff;
      cfg.credit_load  = csr_valid && (csr_index == tbs_pkg::CSR_BUCKET_DEPTH);
   end

   tbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_now    (req_tdata[31:0]),
      .req_tag    (req_tdata[47:32]),
      .req_size   (req_tdata[63:48]),
      .rate       (rate_ff),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_item  (push_item)
   );

   tbs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   tbs_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (pop_valid),
      .q_item     (pop_item),
      .q_pop      (pop),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_tag    (rsp_tag),
      .rsp_size   (rsp_size),
      .rsp_credit (rsp_credit),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_credit, rsp_size, rsp_tag};
   assign rsp_tuser = rsp_status;

endmodule

// ===== hw/rtl/tbs_front.sv =====
// Front end: accepts items, tracks time and works out the refill per item.
module tbs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [tbs_pkg::TIME_W-1:0]    req_now,
   input  logic [tbs_pkg::TAG_W-1:0]     req_tag,
   input  logic [tbs_pkg::SIZE_W-1:0]    req_size,
   input  logic [tbs_pkg::CREDIT_W-1:0]  rate,
   output logic                          push_valid,
   input  logic                          push_full,
   output tbs_pkg::item_type             push_item
);

   logic                          advance;
   logic [tbs_pkg::TIME_W-1:0]    last_time_ff, last_time_in;

   // Stage 1: elapsed time
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_kind_ff, s1_kind_in;
   logic [tbs_pkg::TAG_W-1:0]     s1_tag_ff, s1_tag_in;
   logic [tbs_pkg::SIZE_W-1:0]    s1_size_ff, s1_size_in;
   logic [tbs_pkg::TIME_W-1:0]    s1_elapsed_ff, s1_elapsed_in;

   // Stage 2: elapsed times rate
   logic                          s2_valid_ff, s2_valid_in;
   logic                          s2_kind_ff, s2_kind_in;
   logic [tbs_pkg::TAG_W-1:0]     s2_tag_ff, s2_tag_in;
   logic [tbs_pkg::SIZE_W-1:0]    s2_size_ff, s2_size_in;
   logic [tbs_pkg::PROD_W-1:0]    s2_prod_ff, s2_prod_in;

   // Stage 3: partial products of the divide by ten
   logic                          s3_valid_ff, s3_valid_in;
   logic                          s3_kind_ff, s3_kind_in;
   logic [tbs_pkg::TAG_W-1:0]     s3_tag_ff, s3_tag_in;
   logic [tbs_pkg::SIZE_W-1:0]    s3_size_ff, s3_size_in;
   logic                          s3_sat_ff, s3_sat_in;
   logic [51:0]                   s3_pp_hi_ff, s3_pp_hi_in;
   logic [52:0]                   s3_pp_lo_ff, s3_pp_lo_in;

   logic [69:0]                   quot_sum;

   // The whole pipe moves unless its last stage is blocked by a full FIFO
   assign advance   = !s3_valid_ff || !push_full;
   assign req_ready = advance;

   always_comb begin
      last_time_in  = last_time_ff;
      s1_valid_in   = s1_valid_ff;
      s1_kind_in    = s1_kind_ff;
      s1_tag_in     = s1_tag_ff;
      s1_size_in    = s1_size_ff;
      s1_elapsed_in = s1_elapsed_ff;
      s2_valid_in   = s2_valid_ff;
      s2_kind_in    = s2_kind_ff;
      s2_tag_in     = s2_tag_ff;
      s2_size_in    = s2_size_ff;
      s2_prod_in    = s2_prod_ff;
      s3_valid_in   = s3_valid_ff;
      s3_kind_in    = s3_kind_ff;
      s3_tag_in     = s3_tag_ff;
      s3_size_in    = s3_size_ff;
      s3_sat_in     = s3_sat_ff;
      s3_pp_hi_in   = s3_pp_hi_ff;
      s3_pp_lo_in   = s3_pp_lo_ff;
      if (advance) begin
         // modular time difference; the stamp is taken on acceptance
         s1_valid_in   = req_valid;
         s1_kind_in    = req_kind;
         s1_tag_in     = req_tag;
         s1_size_in    = req_size;
         s1_elapsed_in = req_now - last_time_ff;
         if (req_valid) begin
            last_time_in = req_now;
         end
         s2_valid_in = s1_valid_ff;
         s2_kind_in  = s1_kind_ff;
         s2_tag_in   = s1_tag_ff;
         s2_size_in  = s1_size_ff;
         s2_prod_in  = tbs_pkg::PROD_W'(s1_elapsed_ff) * tbs_pkg::PROD_W'(rate);
         s3_valid_in = s2_valid_ff;
         s3_kind_in  = s2_kind_ff;
         s3_tag_in   = s2_tag_ff;
         s3_size_in  = s2_size_ff;
         s3_sat_in   = (s2_prod_ff >= tbs_pkg::SAT_LIMIT);
         s3_pp_hi_in = 52'(s2_prod_ff[34:18]) * 52'(tbs_pkg::RECIP_10);
         s3_pp_lo_in = 53'(s2_prod_ff[17:0]) * 53'(tbs_pkg::RECIP_10);
      end
   end

   // Recombine the partial products and drop the fraction
   assign quot_sum = {s3_pp_hi_ff, 18'b0} + 70'(s3_pp_lo_ff);

   always_comb begin
      push_valid       = s3_valid_ff;
      push_item.kind   = s3_kind_ff;
      push_item.tag    = s3_tag_ff;
      push_item.size   = s3_size_ff;
      push_item.refill = s3_sat_ff ? 32'h8000_0000
                                   : {1'b0, quot_sum[tbs_pkg::RECIP_SHIFT +: 31]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         last_time_ff <= last_time_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff    <= s1_kind_in;
      s1_tag_ff     <= s1_tag_in;
      s1_size_ff    <= s1_size_in;
      s1_elapsed_ff <= s1_elapsed_in;
      s2_kind_ff    <= s2_kind_in;
      s2_tag_ff     <= s2_tag_in;
      s2_size_ff    <= s2_size_in;
      s2_prod_ff    <= s2_prod_in;
      s3_kind_ff    <= s3_kind_in;
      s3_tag_ff     <= s3_tag_in;
      s3_size_ff    <= s3_size_in;
      s3_sat_ff     <= s3_sat_in;
      s3_pp_hi_ff   <= s3_pp_hi_in;
      s3_pp_lo_ff   <= s3_pp_lo_in;
   end

endmodule

// ===== hw/rtl/tbs_fifo.sv =====
// Short FIFO of classified items between the front and back ends.
module tbs_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_full,
   input  tbs_pkg::item_type  push_item,
   output logic               pop_valid,
   input  logic               pop,
   output tbs_pkg::item_type  pop_item
);

   tbs_pkg::item_type                  entry_ff [tbs_pkg::FIFO_DEPTH];
   logic [tbs_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tbs_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tbs_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic                               do_push, do_pop;

   assign push_full = (count_ff == tbs_pkg::FIFO_CNT_W'(tbs_pkg::FIFO_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/tbs_back.sv =====
// Back end: bucket credit, packet descriptor queue and result register.
module tbs_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tbs_pkg::cfg_type              cfg,
   input  logic                          q_valid,
   input  tbs_pkg::item_type             q_item,
   output logic                          q_pop,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output tbs_pkg::status_type           rsp_status,
   output logic [tbs_pkg::TAG_W-1:0]     rsp_tag,
   output logic [tbs_pkg::SIZE_W-1:0]    rsp_size,
   output logic [tbs_pkg::CREDIT_W-1:0]  rsp_credit,
   output logic                          rsp_last
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tbs_pkg::back_state_type              state_ff, state_in;
   logic [tbs_pkg::CREDIT_W-1:0]         credit_ff, credit_in;
   logic [IDX_W-1:0]                     head_ff, head_in;
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic                                 kind_ff, kind_in;
   logic [tbs_pkg::TAG_W-1:0]            tag_ff, tag_in;
   logic [tbs_pkg::SIZE_W-1:0]           size_ff, size_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   tbs_pkg::status_type                  rsp_status_ff, rsp_status_in;
   logic [tbs_pkg::TAG_W-1:0]            rsp_tag_ff, rsp_tag_in;
   logic [tbs_pkg::SIZE_W-1:0]           rsp_size_ff, rsp_size_in;
   logic [tbs_pkg::CREDIT_W-1:0]         rsp_credit_ff, rsp_credit_in;
   logic                                 rsp_last_ff, rsp_last_in;

   // Descriptor store, read data registered
   logic [tbs_pkg::TAG_W-1:0]            slot_tag_mem  [QUEUE_DEPTH];
   logic [tbs_pkg::SIZE_W-1:0]           slot_size_mem [QUEUE_DEPTH];
   logic [tbs_pkg::TAG_W-1:0]            rd_tag_ff;
   logic [tbs_pkg::SIZE_W-1:0]           rd_size_ff;
   logic                                 rd_en, wr_en;

   logic                                 out_free;
   logic                                 head_fits;
   logic [tbs_pkg::CREDIT_W+1:0]         refill_sum;
   logic [CNT_W:0]                       tail_sum;
   logic [IDX_W-1:0]                     tail_idx;
   logic [IDX_W-1:0]                     head_next;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign head_fits  = (credit_ff >= tbs_pkg::CREDIT_W'(rd_size_ff));
   assign refill_sum = (tbs_pkg::CREDIT_W+2)'(credit_ff) + (tbs_pkg::CREDIT_W+2)'(q_item.refill);
   assign rd_en      = (state_ff == tbs_pkg::B_LOAD);

   // Tail slot and wrapped head
   always_comb begin
      tail_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
      if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
      tail_idx  = tail_sum[IDX_W-1:0];
      head_next = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbs_pkg::B_IDLE: begin
            if (q_valid) begin
               state_in = (count_ff != '0) ? tbs_pkg::B_LOAD : tbs_pkg::B_FINAL;
            end
         end
         tbs_pkg::B_LOAD: begin
            state_in = tbs_pkg::B_CHECK;
         end
         tbs_pkg::B_CHECK: begin
            if (!head_fits) begin
               state_in = tbs_pkg::B_FINAL;
            end else if (out_free) begin
               state_in = (count_ff == CNT_W'(1)) ? tbs_pkg::B_FINAL : tbs_pkg::B_LOAD;
            end
         end
         tbs_pkg::B_FINAL: begin
            if (out_free) begin
               state_in = tbs_pkg::B_IDLE;
            end
         end
         default: state_in = tbs_pkg::B_IDLE;
      endcase
   end

   // Datapath and results
   always_comb begin
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      credit_in     = credit_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      tag_in        = tag_ff;
      size_in       = size_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_credit_in = rsp_credit_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         tbs_pkg::B_IDLE: begin
            // take the next item and refill, saturating at the bucket depth
            if (q_valid) begin
               q_pop   = 1'b1;
               kind_in = q_item.kind;
               tag_in  = q_item.tag;
               size_in = q_item.size;
               if (refill_sum > (tbs_pkg::CREDIT_W+2)'(cfg.bucket_depth)) begin
                  credit_in = cfg.bucket_depth;
               end else begin
                  credit_in = refill_sum[tbs_pkg::CREDIT_W-1:0];
               end
            end
         end
         tbs_pkg::B_CHECK: begin
            // release the head descriptor while it fits
            if (head_fits && out_free) begin
               credit_in     = credit_ff - tbs_pkg::CREDIT_W'(rd_size_ff);
               head_in       = head_next;
               count_in      = count_ff - 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = cfg.out_en ? tbs_pkg::ST_QSENT : tbs_pkg::ST_QDISC;
               rsp_tag_in    = rd_tag_ff;
               rsp_size_in   = rd_size_ff;
               rsp_credit_in = credit_in;
               rsp_last_in   = 1'b0;
            end
         end
         tbs_pkg::B_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_tag_in   = tag_ff;
               rsp_size_in  = size_ff;
               if (kind_ff == tbs_pkg::KIND_TICK) begin
                  rsp_status_in = tbs_pkg::ST_TICK;
                  rsp_tag_in    = '0;
                  rsp_size_in   = '0;
               end else if (count_ff == '0 && credit_ff > tbs_pkg::CREDIT_W'(size_ff)) begin
                  credit_in     = credit_ff - tbs_pkg::CREDIT_W'(size_ff);
                  rsp_status_in = cfg.out_en ? tbs_pkg::ST_SENT : tbs_pkg::ST_DISC;
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  rsp_status_in = tbs_pkg::ST_FULL;
               end else if (size_ff >= tbs_pkg::MAX_PACKET_BYTES) begin
                  rsp_status_in = tbs_pkg::ST_OVERSIZE;
               end else begin
                  wr_en         = 1'b1;
                  count_in      = count_ff + 1'b1;
                  rsp_status_in = tbs_pkg::ST_QUEUED;
               end
               rsp_credit_in = credit_in;
            end
         end
         default: begin
         end
      endcase
      // a write of the bucket depth refills the bucket
      if (cfg.credit_load) begin
         credit_in = cfg.bucket_depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbs_pkg::B_IDLE;
         credit_ff    <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         credit_ff    <= credit_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      tag_ff        <= tag_in;
      size_ff       <= size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_credit_ff <= rsp_credit_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Descriptor store ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_tag_mem[tail_idx]  <= tag_ff;
         slot_size_mem[tail_idx] <= size_ff;
      end
      if (rd_en) begin
         rd_tag_ff  <= slot_tag_mem[head_ff];
         rd_size_ff <= slot_size_mem[head_ff];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_tag    = rsp_tag_ff;
   assign rsp_size   = rsp_size_ff;
   assign rsp_credit = rsp_credit_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== hw/rtl/tbs_checker.sv =====
// Port-level checks of the token bucket packet shaper and their binding.
module tbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result keeps its content
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Only released queued packets come before the last result of an item
   a_early_is_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         rsp_tuser == tbs_pkg::ST_QSENT || rsp_tuser == tbs_pkg::ST_QDISC)
      else $error("non-final result with a final status");

   // Every final-only status is marked last
   a_final_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != tbs_pkg::ST_QSENT && rsp_tuser != tbs_pkg::ST_QDISC
         |-> rsp_tlast)
      else $error("final status without last");

   // A tick result names no packet
   a_tick_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tbs_pkg::ST_TICK |-> rsp_tdata[31:0] == 32'd0)
      else $error("tick result carries a packet");

endmodule

bind token_bucket_packet_shaper tbs_checker u_tbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
